@@ rtl/nlms_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlms_pkg
// Types, constants and command/status structs shared by the echo canceller.
// ----------------------------------------------------------------------------
package nlms_pkg;

    localparam int          SampleW   = 16;
    localparam int          CoefW     = 32;
    localparam int          StepW     = 16;
    localparam logic [15:0] StepReset = 16'd655;
    localparam logic [31:0] RegQ30    = 32'd1074;
    localparam int          NumW      = 56;
    localparam int          DenW      = 48;
    localparam logic [0:0]  AddrStep  = 1'b0;

    typedef struct packed {
        logic signed [15:0] far_sample;
        logic signed [15:0] mic_sample;
        logic               clear_first;
        logic               last_of_block;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] residual;
        logic               block_done;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_MAC,
        ST_RESID,
        ST_DIV,
        ST_UPD,
        ST_OUT,
        ST_INIT
    } t_state;

    typedef struct packed {
        logic load;
        logic clr_step;
        logic mac_step;
        logic resid;
        logic div_start;
        logic div_step;
        logic upd_step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic tap_last;
        logic div_last;
    } t_status;

endpackage

@@ rtl/nlms_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlms_ctrl
// Sequencer: clear sweep, multiply-accumulate pass, residual, division, update pass, result hand-over.
// ----------------------------------------------------------------------------
module nlms_ctrl import nlms_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_clear_first,
    input  logic    i_out_free,
    input  t_status i_status,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_INIT: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_clear_first ? ST_CLEAR : ST_MAC;
                end
            end
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.clr_last) begin
                    n_state = ST_MAC;
                end
            end
            ST_MAC: begin
                o_cmd.mac_step = 1'b1;
                if (i_status.tap_last) begin
                    n_state = ST_RESID;
                end
            end
            ST_RESID: begin
                o_cmd.resid     = 1'b1;
                o_cmd.div_start = 1'b1;
                n_state         = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = ST_UPD;
                end
            end
            ST_UPD: begin
                o_cmd.upd_step = 1'b1;
                if (i_status.tap_last) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (i_out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/nlms_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlms_dp
// Datapath: history and coefficient memories, multiply-accumulate, restoring
// divider and coefficient update.
// ----------------------------------------------------------------------------
module nlms_dp import nlms_pkg::*; #(
    parameter int TAPS = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_cmd            i_cmd,
    input  t_in_item        i_item,
    input  logic [StepW-1:0] i_step,
    output t_status         o_status,
    output logic signed [15:0] o_residual,
    output logic            o_block_done
);

    localparam int AW = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int CW = $clog2(TAPS + 1) + 1;
    localparam logic [AW-1:0] LastIdx = AW'(TAPS - 1);

    logic signed [15:0] r_hist [TAPS];
    logic signed [31:0] r_coef [TAPS];

    logic [AW-1:0] r_newest;
    logic [AW-1:0] r_pos;
    logic [AW-1:0] r_tap;
    logic [AW-1:0] r_ctr;
    logic          r_rd_ok;
    logic [AW-1:0] r_rd_tap;
    logic signed [15:0] r_x;
    logic signed [31:0] r_c;
    logic signed [15:0] r_mic;
    logic               r_last;
    logic signed [63:0] r_acc;
    logic [47:0]        r_pow;
    logic signed [15:0] r_res;
    logic               r_neg;
    logic [NumW-1:0]    r_num;
    logic [DenW-1:0]    r_rem;
    logic [DenW-1:0]    r_den;
    logic [6:0]         r_dcnt;
    logic signed [NumW:0] r_g;
    logic [CW-1:0]      r_cnt;
    logic signed [15:0] r_far;
    logic               r_mode_mac;

    // read pipeline: one read per memory per cycle, data registered
    logic [AW-1:0] w_pos_prev;
    assign w_pos_prev = (r_pos == '0) ? LastIdx : r_pos - 1'b1;

    always_ff @(posedge i_clk) begin
        r_x <= r_hist[r_pos];
        r_c <= r_coef[r_tap];
    end

    logic w_run;
    assign w_run = i_cmd.mac_step || i_cmd.upd_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ok <= 1'b0;
        end else begin
            r_rd_ok <= w_run && (r_cnt < CW'(TAPS));
        end
        r_rd_tap <= r_tap;
    end

    assign o_status.tap_last = w_run && (r_cnt == CW'(TAPS)) && !r_rd_ok;
    assign o_status.clr_last = i_cmd.clr_step && (r_ctr == LastIdx);
    assign o_status.div_last = i_cmd.div_step && (r_dcnt == 7'd1);

    // products
    logic signed [47:0] w_prod;
    logic signed [31:0] w_xx;
    assign w_prod = r_c * r_x;
    assign w_xx   = r_x * r_x;

    // update term
    logic signed [NumW+16:0] w_gx;
    logic signed [NumW+5:0]  w_d;
    logic signed [NumW+7:0]  w_sum;
    logic signed [31:0]      w_new;
    assign w_gx  = r_g * r_x;
    assign w_d   = $signed(w_gx[NumW+16:11]) + $signed({1'b0, w_gx[10]});
    assign w_sum = (NumW+8)'(w_d) + (NumW+8)'(r_c);
    assign w_new = (w_sum > (NumW+8)'(64'sh7FFFFFFF)) ? 32'sh7FFFFFFF :
                   (w_sum < -(NumW+8)'(64'sh80000000)) ? 32'sh80000000 :
                   w_sum[31:0];

    // residual
    logic signed [64:0] w_diff;
    logic signed [35:0] w_r;
    logic signed [15:0] w_rs;
    assign w_diff = ($signed({{49{r_mic[15]}}, r_mic}) <<< 29) - 65'(r_acc)
                    + 65'sd268435456;
    assign w_r    = w_diff[64:29];
    assign w_rs   = (w_r > 36'sd32767) ? 16'sh7FFF :
                    (w_r < -36'sd32768) ? 16'sh8000 : w_r[15:0];

    logic signed [32:0] w_q;
    logic [31:0]        w_qm;
    assign w_q  = $signed({1'b0, i_step}) * w_rs;
    assign w_qm = w_q[32] ? 32'(-w_q) : w_q[31:0];

    logic [DenW:0] w_trial;
    assign w_trial = {r_rem, r_num[NumW-1]} - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_newest <= '0;
        end else if (i_cmd.load && i_item.clear_first) begin
            r_newest <= '0;
        end else if (i_cmd.finish) begin
            r_newest <= (r_newest == LastIdx) ? '0 : r_newest + 1'b1;
        end

        if (i_cmd.load) begin
            r_mic  <= i_item.mic_sample;
            r_last <= i_item.last_of_block;
        end
        // newest sample goes into the history before the pass starts
        if (i_cmd.load && !i_item.clear_first) begin
            r_hist[r_newest] <= i_item.far_sample;
        end
        if (i_cmd.clr_step) begin
            r_hist[r_ctr] <= (r_ctr == '0) ? r_far : '0;
            r_coef[r_ctr] <= '0;
        end
        if (i_cmd.load || i_cmd.clr_step) begin
            r_pos <= (i_cmd.load && i_item.clear_first) ? '0 : r_newest;
            r_tap <= '0;
            r_cnt <= '0;
            r_acc <= '0;
            r_pow <= 48'(RegQ30);
        end
        if (w_run) begin
            if (r_cnt < CW'(TAPS)) begin
                r_pos <= w_pos_prev;
                r_tap <= r_tap + 1'b1;
                r_cnt <= r_cnt + 1'b1;
            end
            if (o_status.tap_last) begin
                r_pos <= r_newest;
                r_tap <= '0;
                r_cnt <= '0;
            end
        end
        if (r_rd_ok && r_mode_mac) begin
            r_acc <= r_acc + 64'(w_prod);
            r_pow <= r_pow + 48'($unsigned(w_xx));
        end
        if (r_rd_ok && !r_mode_mac) begin
            r_coef[r_rd_tap] <= w_new;
        end
        if (i_cmd.resid) begin
            r_res  <= w_rs;
            r_neg  <= w_q[32];
            r_num  <= {w_qm, 24'd0};
            r_rem  <= '0;
            r_den  <= r_pow;
            r_dcnt <= 7'(NumW);
        end
        if (i_cmd.div_step) begin
            if (!w_trial[DenW]) begin
                r_rem <= w_trial[DenW-1:0];
            end else begin
                r_rem <= {r_rem[DenW-2:0], r_num[NumW-1]};
            end
            r_num  <= {r_num[NumW-2:0], !w_trial[DenW]};
            r_dcnt <= r_dcnt - 1'b1;
        end
        if (o_status.div_last) begin
            r_g <= r_neg ? -$signed({1'b0, r_num[NumW-2:0], !w_trial[DenW]})
                         : $signed({1'b0, r_num[NumW-2:0], !w_trial[DenW]});
        end
    end

    // clear sweep counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.load) begin
            r_ctr <= '0;
        end else if (i_cmd.clr_step) begin
            r_ctr <= r_ctr + 1'b1;
        end
    end

    // far sample latch and pass mode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode_mac <= 1'b1;
            r_far      <= '0;
        end else begin
            if (i_cmd.mac_step) begin
                r_mode_mac <= 1'b1;
            end else if (i_cmd.upd_step) begin
                r_mode_mac <= 1'b0;
            end
            if (i_cmd.load) begin
                r_far <= i_item.far_sample;
            end
        end
    end

    assign o_residual   = r_res;
    assign o_block_done = r_last;

endmodule

@@ rtl/nlms_echo_canceller.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlms_echo_canceller
// NLMS adaptive FIR echo canceller with APB step-size register.
// ----------------------------------------------------------------------------
// One item at a time: an item passes through an accept step, a
// multiply-accumulate pass over the coefficient and history memories, a
// residual step, a restoring division for the gain, an update pass and a
// hand-over of the result that waits until the result register is free;
// when clear_first is set, a sweep of both memories comes before the
// multiply-accumulate pass. After reset a sweep clears both memories before
// the first item is taken. The result sits in an output register so the
// next item is taken while it waits.
module nlms_echo_canceller import nlms_pkg::*; #(
    parameter int TAPS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [StepW-1:0] r_step;
    t_cmd             w_cmd;
    t_status          w_status;
    logic signed [15:0] w_res;
    logic             w_done;
    logic             r_out_valid;
    t_out_item        r_out_item;
    logic             w_out_free;

    assign pready = 1'b1;
    assign prdata = (paddr[1] == AddrStep) ? {16'd0, r_step} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= StepReset;
        end else if (psel && penable && pwrite && paddr[1] == AddrStep) begin
            r_step <= pwdata[15:0];
        end
    end

    assign w_out_free = !r_out_valid || i_out_ready;

    nlms_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_clear_first(i_in_item.clear_first),
        .i_out_free   (w_out_free),
        .i_status     (w_status),
        .o_in_ready   (o_in_ready),
        .o_cmd        (w_cmd)
    );

    nlms_dp #(.TAPS(TAPS)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_item       (i_in_item),
        .i_step       (r_step),
        .o_status     (w_status),
        .o_residual   (w_res),
        .o_block_done (w_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_cmd.finish) begin
            r_out_item.residual   <= w_res;
            r_out_item.block_done <= w_done;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

@@ rtl/nlms_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlms_checker
// Port-level checks for the echo canceller.
// ----------------------------------------------------------------------------
module nlms_checker import nlms_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_item,
    input logic      pready
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result item changed while stalled");

    a_one_at_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second item taken while busy");

    a_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !o_out_valid |=> !o_out_valid)
        else $error("result before work done");

    a_pready: assert property (@(posedge i_clk) pready)
        else $error("pready low");

endmodule

bind nlms_echo_canceller nlms_checker u_nlms_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item),
    .pready      (pready)
);
